[design/sspd_pkg.sv]
// Shared types and constants for the stepper speed/step controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package sspd_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MMS   = 2'd1;
    localparam logic [1:0] KIND_STEPS = 2'd2;
    localparam logic [1:0] KIND_COUNT = 2'd3;

    localparam logic [1:0] REG_MAX_SPEED    = 2'd0;
    localparam logic [1:0] REG_DEADBAND     = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS   = 2'd2;
    localparam logic [1:0] REG_PERIOD_SCALE = 2'd3;

    localparam logic [11:0] RST_MAX_SPEED    = 12'd128;
    localparam logic [6:0]  RST_DEADBAND     = 7'd4;
    localparam logic [7:0]  RST_HOLD_TICKS   = 8'd10;
    localparam logic [11:0] RST_PERIOD_SCALE = 12'd1280;

    localparam int VALUE_W  = 24;
    localparam int OUT_W    = 40;
    localparam int DIVSR_W  = 12;

    typedef struct packed {
        logic [11:0] max_speed;
        logic [6:0]  deadband;
        logic [7:0]  hold_ticks;
        logic [11:0] period_scale;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic start_div;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
    } sts_t;

endpackage

[design/stepper_speed_step_controller.sv]
// Stepper channel speed and step controller with an APB register port.
// Items that need no division go straight to the result register; a stepping tick or a
// mm/s speed command with a nonzero max speed first runs the one-bit-per-cycle serial
// divider.
// One item is in work at a time; the next is taken only after its result is stored.
// Reset is asynchronous: the channel state clears and the registers take their defaults.
module stepper_speed_step_controller
    import sspd_pkg::*;
#(
    parameter int FULL_SPEED      = 128,
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // value[23:0]
    input  logic [VALUE_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // drive_phase[1:0], coils_on[2], stepped[3], move_done[4], in_step_mode[5],
    // steps_remaining[29:6], current_speed[38:30], zero pad[39]
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t       cfg_reg, cfg_next;
    cmd_t       cmd;
    sts_t       sts;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_SPEED:    cfg_next.max_speed    = pwdata[11:0];
                REG_DEADBAND:     cfg_next.deadband     = pwdata[6:0];
                REG_HOLD_TICKS:   cfg_next.hold_ticks   = pwdata[7:0];
                REG_PERIOD_SCALE: cfg_next.period_scale = pwdata[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_SPEED:    prdata = 32'(cfg_reg.max_speed);
            REG_DEADBAND:     prdata = 32'(cfg_reg.deadband);
            REG_HOLD_TICKS:   prdata = 32'(cfg_reg.hold_ticks);
            REG_PERIOD_SCALE: prdata = 32'(cfg_reg.period_scale);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed    <= RST_MAX_SPEED;
            cfg_reg.deadband     <= RST_DEADBAND;
            cfg_reg.hold_ticks   <= RST_HOLD_TICKS;
            cfg_reg.period_scale <= RST_PERIOD_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sspd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sspd_dp #(
        .FULL_SPEED      (FULL_SPEED),
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg_reg),
        .in_kind  (s_tuser),
        .in_value (s_tdata),
        .out_data (m_tdata)
    );

endmodule

[design/sspd_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Stand-alone unit used by the datapath; no package dependency.
module sspd_div #(
    parameter int DW = 32,
    parameter int VW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW:0]     rem_sh;
    logic [VW:0]     diff;
    logic            geq;

    assign rem_sh = {rem_reg, q_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, divisor};
    assign geq    = rem_sh >= {1'b0, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNTW'(DW);
            q_next   = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = {q_reg[DW-2:0], geq};
            rem_next = geq ? diff[VW-1:0] : rem_sh[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

[design/sspd_ctrl.sv]
// Sequencing state machine of the stepper controller.
// Uses sspd_pkg for the command and status structs.
module sspd_ctrl
    import sspd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.need_div)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[design/sspd_dp.sv]
// Datapath of the stepper controller: item register, channel state, result register.
// Uses sspd_pkg and instantiates the serial divider sspd_div.
module sspd_dp
    import sspd_pkg::*;
#(
    parameter int FULL_SPEED      = 128,
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  cfg_t               cfg,
    input  logic [1:0]         in_kind,
    input  logic [VALUE_W-1:0] in_value,
    output logic [OUT_W-1:0]   out_data
);

    localparam int MAGW = $clog2(FULL_SPEED + 1);
    localparam int SW   = MAGW + 1;
    localparam int DW   = VALUE_W + MAGW;
    localparam int CW   = STEP_COUNT_BITS;
    localparam int MW   = (CW > VALUE_W) ? CW : VALUE_W;
    localparam int EW   = (SW > 9) ? SW : 9;

    localparam logic signed [SW-1:0]      FS_POS = SW'(FULL_SPEED);
    localparam logic signed [SW-1:0]      FS_NEG = -FS_POS;
    localparam logic signed [VALUE_W-1:0] FS_V   = VALUE_W'(FULL_SPEED);
    localparam logic [MW-1:0]             CMAX   = MW'({CW{1'b1}});

    logic [1:0]                kind_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic [1:0]               phase_reg, phase_next;
    logic [1:0]               driven_reg, driven_next;
    logic                     energised_reg, energised_next;
    logic [12:0]              countdown_reg, countdown_next;
    logic [7:0]               idle_reg, idle_next;
    logic signed [SW-1:0]     speed_reg, speed_next;
    logic [CW-1:0]            steps_reg, steps_next;
    logic                     counted_reg, counted_next;
    logic                     stepped, done;

    logic [OUT_W-1:0]         out_reg;

    logic [VALUE_W-1:0]       mag_v;
    logic [MAGW-1:0]          mag;
    logic                     in_db;
    logic                     due;
    logic [DW-1:0]            dividend;
    logic [DIVSR_W-1:0]       divisor;
    logic                     div_busy;
    logic [DW-1:0]            quot;
    logic [MAGW-1:0]          qmag;
    logic [MW-1:0]            m_ext;
    logic [MW-1:0]            steps_ext;
    logic signed [EW-1:0]     speed_ext;

    assign mag_v = value_reg[VALUE_W-1] ? VALUE_W'(-value_reg) : VALUE_W'(value_reg);
    assign mag   = speed_reg[SW-1] ? MAGW'(-speed_reg) : MAGW'(speed_reg);
    assign in_db = DIVSR_W'(mag) <= DIVSR_W'(cfg.deadband);
    assign due   = countdown_reg <= 13'd1;

    assign dividend = (kind_reg == KIND_MMS) ? DW'(mag_v) * DW'(FULL_SPEED)
                                             : DW'(cfg.period_scale);
    assign divisor  = (kind_reg == KIND_MMS) ? cfg.max_speed : DIVSR_W'(mag);

    assign sts.need_div = ((kind_reg == KIND_MMS) && (cfg.max_speed != '0)) ||
                          ((kind_reg == KIND_TICK) && !in_db && due);
    assign sts.div_busy = div_busy;

    sspd_div #(
        .DW (DW),
        .VW (DIVSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign qmag  = (quot > DW'(FULL_SPEED)) ? MAGW'(FULL_SPEED) : MAGW'(quot);
    assign m_ext = MW'(mag_v);

    always_comb
    begin
        phase_next     = phase_reg;
        driven_next    = driven_reg;
        energised_next = energised_reg;
        countdown_next = countdown_reg;
        idle_next      = idle_reg;
        speed_next     = speed_reg;
        steps_next     = steps_reg;
        counted_next   = counted_reg;
        stepped        = 1'b0;
        done           = 1'b0;
        case (kind_reg)
            KIND_TICK:
            begin
                if (in_db)
                begin
                    energised_next = 1'b0;
                end
                else
                begin
                    if (due)
                    begin
                        phase_next     = speed_reg[SW-1] ? phase_reg + 2'd3
                                                         : phase_reg + 2'd1;
                        countdown_next = quot[12:0];
                        idle_next      = '0;
                        stepped        = 1'b1;
                        if (counted_reg && (steps_reg != '0))
                        begin
                            steps_next = steps_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 13'd1;
                        if (idle_reg < cfg.hold_ticks)
                        begin
                            idle_next = idle_reg + 8'd1;
                        end
                    end
                    if (!due && (idle_reg >= cfg.hold_ticks))
                    begin
                        energised_next = 1'b0;
                    end
                    else if (counted_reg && (steps_next == '0))
                    begin
                        counted_next = 1'b0;
                        speed_next   = '0;
                        done         = 1'b1;
                    end
                    else
                    begin
                        driven_next    = phase_next;
                        energised_next = 1'b1;
                    end
                end
            end
            KIND_MMS:
            begin
                if (cfg.max_speed == '0)
                begin
                    if (value_reg == '0)
                    begin
                        speed_next = '0;
                    end
                    else
                    begin
                        speed_next = value_reg[VALUE_W-1] ? FS_NEG : FS_POS;
                    end
                end
                else
                begin
                    speed_next = value_reg[VALUE_W-1] ? -$signed({1'b0, qmag})
                                                      : $signed({1'b0, qmag});
                end
            end
            KIND_STEPS:
            begin
                if (value_reg > FS_V)
                begin
                    speed_next = FS_POS;
                end
                else if (value_reg < -FS_V)
                begin
                    speed_next = FS_NEG;
                end
                else
                begin
                    speed_next = SW'(value_reg);
                end
            end
            KIND_COUNT:
            begin
                if (value_reg == '0)
                begin
                    counted_next = 1'b0;
                    steps_next   = '0;
                end
                else
                begin
                    counted_next = 1'b1;
                    speed_next   = value_reg[VALUE_W-1] ? FS_NEG : FS_POS;
                    steps_next   = (m_ext > CMAX) ? CW'(CMAX) : CW'(m_ext);
                end
            end
            default:
            begin
                speed_next = speed_reg;
            end
        endcase
    end

    assign steps_ext = MW'(steps_next);
    assign speed_ext = EW'(speed_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            driven_reg    <= '0;
            energised_reg <= 1'b0;
            countdown_reg <= '0;
            idle_reg      <= '0;
            speed_reg     <= '0;
            steps_reg     <= '0;
            counted_reg   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg     <= phase_next;
            driven_reg    <= driven_next;
            energised_reg <= energised_next;
            countdown_reg <= countdown_next;
            idle_reg      <= idle_next;
            speed_reg     <= speed_next;
            steps_reg     <= steps_next;
            counted_reg   <= counted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
        end
        if (cmd.commit)
        begin
            out_reg <= {1'b0, speed_ext[8:0], steps_ext[23:0], counted_next, done,
                        stepped, energised_next, driven_next};
        end
    end

    assign out_data = out_reg;

endmodule
